// ----- design/ecpr_pkg.sv -----
// shared types and codes for the clock page replacer
`default_nettype none
package ecpr_pkg;
  localparam int FuncW = 2;
  localparam int FrameW = 3;
  localparam int PageW = 20;
  localparam int SwapW = 28;
  localparam int SwapShift = 8;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_ACCESS = 2'd1,
    FN_EVICT = 2'd2,
    FN_TICK = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KD_DONE = 2'd0,
    KD_VICTIM = 2'd1,
    KD_WB = 2'd2,
    KD_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [FrameW-1:0] frame;
    logic [PageW-1:0] page_number;
    logic is_write;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [FrameW-1:0] frame_out;
    logic [PageW-1:0] page_out;
    logic write_back_needed;
    logic [SwapW-1:0] swap_slot;
    logic last;
  } out_word_t;

  // controller commands to the datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INSERT,
    CMD_ACCESS,
    CMD_EV_START,
    CMD_EV_STEP,
    CMD_EV_UNLINK,
    CMD_TK_STEP
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic ins_bad;
    logic cur_clear;
    logic cur_pending;
    logic tk_more;
    logic pend_last;
  } status_t;
endpackage
`default_nettype wire

// ----- design/ecpr_if.sv -----
// valid/ready channel interface carrying one packed word
`default_nettype none
interface ecpr_if #(parameter type word_t = logic);
  logic valid;
  logic ready;
  word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/ecpr_datapath.sv -----
// frame ring storage, hand and scan cursor
`default_nettype none
module ecpr_datapath #(
  parameter int FRAMES = 8,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input wire logic clk,
  input wire logic rst,
  input wire ecpr_pkg::cmd_t cmd,
  input wire ecpr_pkg::in_word_t in_word,
  output ecpr_pkg::status_t status,
  output ecpr_pkg::out_word_t res
);
  import ecpr_pkg::*;
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [IW-1:0] nxt [FRAMES];
  logic [IW-1:0] prv [FRAMES];
  logic [PAGE_NUMBER_BITS-1:0] tag [FRAMES];
  logic [FRAMES-1:0] res_m, acc_m, dirty_m, pend_m, copy_m;
  logic [IW-1:0] hand, cur;
  logic [CW-1:0] count, left;
  in_word_t iw;

  logic f_ok;
  logic [IW-1:0] fi;
  logic [IW-1:0] hp, cn, cp;
  logic [PAGE_NUMBER_BITS-1:0] ctag;
  logic [PageW-1:0] cpage;
  logic [FRAMES-1:0] pend_res;

  assign f_ok = 32'(iw.frame) < FRAMES;
  assign fi = IW'(iw.frame);
  assign hp = prv[hand];
  assign cn = nxt[cur];
  assign cp = prv[cur];
  assign ctag = tag[cur];
  assign cpage = PageW'(ctag);
  // resident frames still waiting for a write-back
  assign pend_res = pend_m & res_m;

  assign status.empty = count == '0;
  assign status.ins_bad = !f_ok || res_m[fi];
  assign status.cur_clear = !acc_m[cur] && !dirty_m[cur];
  assign status.cur_pending = pend_m[cur];
  assign status.tk_more = left != '0;
  assign status.pend_last = (pend_res & (pend_res - 1'b1)) == '0;

  always_comb begin
    res = '0;
    res.frame_out = FrameW'(cur);
    res.page_out = cpage;
    res.swap_slot = SwapW'((64'(ctag) + 64'd1) << SwapShift);
    res.write_back_needed = (cmd == CMD_EV_UNLINK) ? !copy_m[cur] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_m <= '0; acc_m <= '0; dirty_m <= '0; pend_m <= '0; copy_m <= '0;
      hand <= '0; count <= '0; cur <= '0; left <= '0;
    end else begin
      unique case (cmd)
        CMD_LOAD: iw <= in_word;
        CMD_INSERT: begin
          if (count == '0) begin
            nxt[fi] <= fi; prv[fi] <= fi;
          end else begin
            nxt[hp] <= fi; prv[fi] <= hp; nxt[fi] <= hand; prv[hand] <= fi;
          end
          res_m[fi] <= 1'b1;
          tag[fi] <= PAGE_NUMBER_BITS'(iw.page_number);
          acc_m[fi] <= 1'b0; dirty_m[fi] <= 1'b0;
          pend_m[fi] <= 1'b0; copy_m[fi] <= 1'b0;
          hand <= fi;
          count <= count + 1'b1;
        end
        CMD_ACCESS: begin
          if (f_ok && res_m[fi]) begin
            acc_m[fi] <= 1'b1;
            if (iw.is_write) dirty_m[fi] <= 1'b1;
          end
        end
        CMD_EV_START: begin
          cur <= hand; left <= count;
        end
        CMD_EV_STEP: begin
          if (dirty_m[cur]) begin
            dirty_m[cur] <= 1'b0; pend_m[cur] <= 1'b1;
          end else acc_m[cur] <= 1'b0;
          cur <= cn;
        end
        CMD_EV_UNLINK: begin
          nxt[cp] <= cn; prv[cn] <= cp;
          res_m[cur] <= 1'b0;
          count <= count - 1'b1;
          hand <= (count == CW'(1)) ? '0 : cn;
        end
        CMD_TK_STEP: begin
          if (pend_m[cur]) begin
            pend_m[cur] <= 1'b0; dirty_m[cur] <= 1'b0; copy_m[cur] <= 1'b1;
          end
          cur <= cn;
          left <= left - 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/ecpr_ctrl.sv -----
// sequencer for insert, access, evict scan and tick sweep
`default_nettype none
module ecpr_ctrl (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [1:0] in_func,
  output logic out_valid,
  input wire logic out_ready,
  output ecpr_pkg::cmd_t cmd,
  input wire ecpr_pkg::status_t status,
  input wire ecpr_pkg::out_word_t dp_res,
  output ecpr_pkg::out_word_t out_data
);
  import ecpr_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_EVSCAN, S_TICK, S_TKOUT, S_OUT
  } state_t;

  state_t state;
  logic any_wb;
  logic [1:0] func_r;

  function automatic out_word_t set_kind(out_word_t w, kind_t k, logic lst);
    out_word_t r;
    r = w;
    r.kind = k;
    r.last = lst;
    return r;
  endfunction

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd = CMD_LOAD;
      S_DISPATCH: begin
        unique case (func_t'(func_r))
          FN_INSERT: if (!status.ins_bad) cmd = CMD_INSERT;
          FN_ACCESS: cmd = CMD_ACCESS;
          FN_EVICT: if (!status.empty) cmd = CMD_EV_START;
          FN_TICK: cmd = CMD_EV_START;
          default: ;
        endcase
      end
      S_EVSCAN: cmd = status.cur_clear ? CMD_EV_UNLINK : CMD_EV_STEP;
      S_TICK: if (status.tk_more && !status.cur_pending) cmd = CMD_TK_STEP;
      S_TKOUT: if (out_ready) cmd = CMD_TK_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; any_wb <= 1'b0; func_r <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          func_r <= in_func; any_wb <= 1'b0; state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (func_t'(func_r))
            FN_INSERT: begin
              if (status.ins_bad) out_data <= set_kind('0, KD_ERROR, 1'b1);
              else out_data <= set_kind('0, KD_DONE, 1'b1);
              out_valid <= 1'b1; state <= S_OUT;
            end
            FN_ACCESS: begin
              out_data <= set_kind('0, KD_DONE, 1'b1);
              out_valid <= 1'b1; state <= S_OUT;
            end
            FN_EVICT: begin
              if (status.empty) begin
                out_data <= set_kind('0, KD_ERROR, 1'b1);
                out_valid <= 1'b1; state <= S_OUT;
              end else state <= S_EVSCAN;
            end
            default: state <= S_TICK;
          endcase
        end
        S_EVSCAN: if (status.cur_clear) begin
          out_data <= set_kind(dp_res, KD_VICTIM, 1'b1);
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_TICK: begin
          if (!status.tk_more) begin
            if (!any_wb) begin
              out_data <= set_kind('0, KD_DONE, 1'b1);
              out_valid <= 1'b1; state <= S_OUT;
            end else state <= S_IDLE;
          end else if (status.cur_pending) begin
            // final request when this frame is the only one still pending
            out_data <= set_kind(dp_res, KD_WB, status.pend_last);
            out_valid <= 1'b1; any_wb <= 1'b1; state <= S_TKOUT;
          end
        end
        S_TKOUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= S_TICK;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/enhanced_clock_page_replacer.sv -----
// top level of the enhanced second-chance clock page replacer
// usage:
//   in channel carries func, frame, page_number, is_write; out channel
//   carries kind, frame_out, page_out, write_back_needed, swap_slot, last
//   one item is worked at a time; in.ready is high only when idle
//   insert and access: the dispatch state registers the result word, which
//   is then offered in S_OUT; the next word is taken back in idle
//   evict: after dispatch the scan steps on until a clear frame is unlinked;
//   a frame is stepped over at most twice
//   tick: one sweep step per resident frame, held at each write-back word
//   until it is taken, and a done word when nothing is pending; words of
//   one item end with last set
//   a write-back word is final when its frame is the only resident frame
//   still pending
//   reset clears every mark, the hand and the frame count at once
//   when the receiver stalls the block holds its result word and waits
`default_nettype none
module enhanced_clock_page_replacer #(
  parameter int FRAMES = 8,
  parameter int PAGE_NUMBER_BITS = 20
) (
  input wire logic clk,
  input wire logic rst,
  ecpr_if.sink in_ch,
  ecpr_if.source out_ch
);
  import ecpr_pkg::*;
  cmd_t cmd;
  status_t status;
  out_word_t dp_res, held;
  in_word_t iw;
  logic ov;

  assign iw = in_ch.data;

  ecpr_datapath #(.FRAMES(FRAMES), .PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)) u_dp (
    .clk, .rst, .cmd, .in_word(iw), .status, .res(dp_res)
  );

  ecpr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_func(iw.func),
    .out_valid(ov), .out_ready(out_ch.ready),
    .cmd, .status, .dp_res, .out_data(held)
  );

  // result word comes straight from the controller's output register
  assign out_ch.valid = ov;
  assign out_ch.data = held;
endmodule
`default_nettype wire

// ----- design/ecpr_checker.sv -----
// port level checks for the replacer
`default_nettype none
module ecpr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_kind,
  input wire logic out_last
);
  import ecpr_pkg::*;
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("took two items");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KD_WB |-> out_last) else $error("single not last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("dropped word");
endmodule
bind enhanced_clock_page_replacer ecpr_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.data.kind), .out_last(out_ch.data.last)
);
`default_nettype wire

// ----- tb/tb_enhanced_clock_page_replacer.sv -----
// testbench for the clock page replacer: queued driver, predictor, word checker
`default_nettype none
module tb_enhanced_clock_page_replacer;
  import ecpr_pkg::*;

  localparam int NFr = 8;
  localparam int CycleLimit = 400000;
  localparam int LongStart = 60;
  localparam int LongEnd = 360;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  ecpr_if #(.word_t(in_word_t)) in_ch ();
  ecpr_if #(.word_t(out_word_t)) out_ch ();

  enhanced_clock_page_replacer #(.FRAMES(NFr), .PAGE_NUMBER_BITS(PageW)) uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor copy of the ring
  logic [FrameW-1:0] ring_next [NFr];
  logic [FrameW-1:0] ring_prev [NFr];
  logic [PageW-1:0] tag_of [NFr];
  logic resident [NFr];
  logic acc_m [NFr];
  logic dirty_m [NFr];
  logic pend_m [NFr];
  logic copy_m [NFr];
  logic [FrameW-1:0] clk_hand;
  int n_resident;

  in_word_t pending_words [$];   // words still to be offered
  out_word_t expected_words [$]; // predicted result words in order
  int fails = 0;
  logic quiet = 1'b0;            // last part of the run: no idling
  logic hold_long = 1'b0;        // long receiver stall in progress

  function automatic out_word_t mk_word(kind_t k, logic [FrameW-1:0] fr,
                                        logic [PageW-1:0] pg,
                                        logic wb, logic slot, logic lst);
    out_word_t w;
    w.kind = k;
    w.frame_out = fr;
    w.page_out = pg;
    w.write_back_needed = wb;
    w.swap_slot = slot ? SwapW'((28'(pg) + 28'd1) << SwapShift) : '0;
    w.last = lst;
    return w;
  endfunction

  task automatic predict_replacer(in_word_t w);
    logic [FrameW-1:0] f;
    logic [FrameW-1:0] cur;
    logic [FrameW-1:0] p;
    logic [FrameW-1:0] n;
    int cnt;
    f = w.frame;
    case (func_t'(w.func))
      FN_INSERT: begin
        if (resident[f]) begin
          expected_words.push_back(mk_word(KD_ERROR, '0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          if (n_resident == 0) begin
            ring_next[f] = f;
            ring_prev[f] = f;
          end else begin
            p = ring_prev[clk_hand];
            ring_next[p] = f;
            ring_prev[f] = p;
            ring_next[f] = clk_hand;
            ring_prev[clk_hand] = f;
          end
          resident[f] = 1'b1;
          tag_of[f] = w.page_number;
          acc_m[f] = 1'b0;
          dirty_m[f] = 1'b0;
          pend_m[f] = 1'b0;
          copy_m[f] = 1'b0;
          clk_hand = f;
          n_resident++;
          expected_words.push_back(mk_word(KD_DONE, '0, '0, 1'b0, 1'b0, 1'b1));
        end
      end
      FN_ACCESS: begin
        if (resident[f]) begin
          acc_m[f] = 1'b1;
          if (w.is_write) dirty_m[f] = 1'b1;
        end
        expected_words.push_back(mk_word(KD_DONE, '0, '0, 1'b0, 1'b0, 1'b1));
      end
      FN_EVICT: begin
        if (n_resident == 0) begin
          expected_words.push_back(mk_word(KD_ERROR, '0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          cur = clk_hand;
          for (int s = 0; s < 3 * NFr + 1; s++) begin
            if (!dirty_m[cur] && !acc_m[cur]) break;
            if (dirty_m[cur]) begin
              dirty_m[cur] = 1'b0;
              pend_m[cur] = 1'b1;
            end else begin
              acc_m[cur] = 1'b0;
            end
            cur = ring_next[cur];
          end
          n = ring_next[cur];
          p = ring_prev[cur];
          ring_next[p] = n;
          ring_prev[n] = p;
          resident[cur] = 1'b0;
          n_resident--;
          clk_hand = (n_resident == 0) ? '0 : n;
          expected_words.push_back(mk_word(KD_VICTIM, cur, tag_of[cur], !copy_m[cur],
                                           1'b1, 1'b1));
        end
      end
      default: begin
        // write-back sweep, one ring pass from the hand
        cur = clk_hand;
        cnt = 0;
        for (int i = 0; i < n_resident; i++) begin
          if (pend_m[cur]) begin
            pend_m[cur] = 1'b0;
            dirty_m[cur] = 1'b0;
            copy_m[cur] = 1'b1;
            expected_words.push_back(mk_word(KD_WB, cur, tag_of[cur], 1'b1, 1'b1, 1'b0));
            cnt++;
          end
          cur = ring_next[cur];
        end
        if (cnt == 0) expected_words.push_back(mk_word(KD_DONE, '0, '0, 1'b0, 1'b0, 1'b1));
        else expected_words[$].last = 1'b1;
      end
    endcase
  endtask

  function automatic in_word_t mk_in(func_t fn, logic [FrameW-1:0] fr,
                                     logic [PageW-1:0] pg, logic wr);
    in_word_t w;
    w.func = fn;
    w.frame = fr;
    w.page_number = pg;
    w.is_write = wr;
    return w;
  endfunction

  // driver: offers queued words, random idle bursts between words
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_replacer(in_ch.data);
        void'(pending_words.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!quiet && !hold_long && (!in_ch.valid || in_ch.ready) &&
                   $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 17) - 1;
        in_ch.valid <= 1'b0;
      end else if ((in_ch.valid && in_ch.ready) ? pending_words.size() > 1
                                                 : pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= (in_ch.valid && in_ch.ready) ? pending_words[1] : pending_words[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall control: random bursts plus one long hold-off
  int recv_gap = 0;
  int long_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (long_cnt < LongEnd) long_cnt <= long_cnt + 1;
      if (long_cnt >= LongStart && long_cnt < LongEnd) begin
        hold_long <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        hold_long <= 1'b0;
        if (recv_gap > 0) begin
          recv_gap <= recv_gap - 1;
          out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          recv_gap <= $urandom_range(1, 17) - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // monitor: compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    out_word_t e;
    out_word_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (expected_words.size() == 0) begin
        $error("unexpected word kind=%0d frame=%0d", a.kind, a.frame_out);
        fails++;
      end else begin
        e = expected_words.pop_front();
        if (a.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, a.kind); fails++;
        end
        if (a.frame_out !== e.frame_out) begin
          $error("frame_out exp %0d got %0d", e.frame_out, a.frame_out); fails++;
        end
        if (a.page_out !== e.page_out) begin
          $error("page_out exp %h got %h", e.page_out, a.page_out); fails++;
        end
        if (a.write_back_needed !== e.write_back_needed) begin
          $error("write_back_needed exp %b got %b", e.write_back_needed,
                 a.write_back_needed); fails++;
        end
        if (a.swap_slot !== e.swap_slot) begin
          $error("swap_slot exp %h got %h", e.swap_slot, a.swap_slot); fails++;
        end
        if (a.last !== e.last) begin
          $error("last exp %b got %b", e.last, a.last); fails++;
        end
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // random item: weighted mix of insert, access, evict and tick on uniformly chosen frames
  function automatic in_word_t rand_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return mk_in(FN_INSERT, FrameW'($urandom_range(0, NFr - 1)),
                             PageW'($urandom), 1'($urandom));
    if (r < 65) return mk_in(FN_ACCESS, FrameW'($urandom_range(0, NFr - 1)),
                             PageW'($urandom), 1'($urandom));
    if (r < 85) return mk_in(FN_EVICT, FrameW'($urandom_range(0, NFr - 1)),
                             PageW'($urandom), 1'($urandom));
    return mk_in(FN_TICK, FrameW'($urandom_range(0, NFr - 1)),
                 PageW'($urandom), 1'($urandom));
  endfunction

  initial begin
    for (int i = 0; i < NFr; i++) begin
      resident[i] = 1'b0; acc_m[i] = 1'b0; dirty_m[i] = 1'b0;
      pend_m[i] = 1'b0; copy_m[i] = 1'b0;
      ring_next[i] = '0; ring_prev[i] = '0; tag_of[i] = '0;
    end
    clk_hand = '0;
    n_resident = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty evict, tick on empty, field extremes, duplicate insert,
    // access of a non-resident frame, write and read accesses, victim sweeps
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_TICK, 3'd7, '1, 1'b1));
    pending_words.push_back(mk_in(FN_ACCESS, 3'd3, '0, 1'b1));
    pending_words.push_back(mk_in(FN_INSERT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_INSERT, 3'd7, '1, 1'b1));
    pending_words.push_back(mk_in(FN_INSERT, 3'd7, 20'h12345, 1'b0));
    pending_words.push_back(mk_in(FN_INSERT, 3'd3, 20'h55555, 1'b0));
    pending_words.push_back(mk_in(FN_INSERT, 3'd4, 20'haaaaa, 1'b1));
    pending_words.push_back(mk_in(FN_ACCESS, 3'd7, '1, 1'b1));
    pending_words.push_back(mk_in(FN_ACCESS, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_ACCESS, 3'd3, '0, 1'b1));
    pending_words.push_back(mk_in(FN_ACCESS, 3'd4, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_TICK, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));
    pending_words.push_back(mk_in(FN_EVICT, 3'd0, '0, 1'b0));

    // backlog for the long receiver hold-off, driver keeps offering
    for (int i = 0; i < 20; i++) pending_words.push_back(rand_item());

    for (int i = 0; i < 110; i++) begin
      while (pending_words.size() > 8) @(posedge clk);
      if (i == 90) quiet <= 1'b1;
      // keep the ring populated now and then with a full refill
      if (i % 40 == 0)
        for (int f = 0; f < NFr; f++)
          pending_words.push_back(mk_in(FN_INSERT, FrameW'(f), PageW'($urandom), 1'b0));
      pending_words.push_back(rand_item());
    end

    while (pending_words.size() > 0 || expected_words.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
design/ecpr_pkg.sv
design/ecpr_if.sv
design/ecpr_datapath.sv
design/ecpr_ctrl.sv
design/enhanced_clock_page_replacer.sv
design/ecpr_checker.sv
tb/tb_enhanced_clock_page_replacer.sv
